/* rtl/core/pf_pkg.sv */
// Shared types and constants for the prime factorisation core.
// Holds field widths, the controller state encoding and the command/status bundles.
// No dependencies; compiled first.
package pf_pkg;

  // Field widths
  localparam int unsigned NUM_W   = 31;  // value to factor, factors out
  localparam int unsigned F_W     = 17;  // trial divisor; stays below sqrt(2^31) + 1
  localparam int unsigned DIG_W   = 17;  // normalised mixed-radix digit
  localparam int unsigned R_W     = F_W + 1;  // radix f + i
  localparam int unsigned MAX_RUN = 30;  // longest run of factors for one value
  localparam int unsigned RUN_W   = $clog2(MAX_RUN + 1);

  localparam logic [F_W-1:0] F_START = F_W'(2);

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_CONV_INIT,
    S_CONV,
    S_CONV_WAIT,
    S_CHECK,
    S_PASS_INIT,
    S_STEP_MUL,
    S_STEP_FIX,
    S_PASS_END,
    S_TRIM,
    S_RESULT,
    S_DIV,
    S_DIV_WAIT,
    S_EMIT
  } pf_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_n;       // take a new value from the input channel
    logic conv_init;    // x <= n, top <= 0, f <= 2
    logic div_start;    // launch the shared divider
    logic div_conv;     // divider operands: x / (top + 2) instead of n / p
    logic conv_store;   // digit[top] <= remainder, x <= quotient
    logic top_inc;
    logic top_dec;
    logic rd_sel_top;   // digit read port addresses top instead of i + 1
    logic pass_init;    // f <= f + 1, i <= 0, cur <= digit[0]
    logic step_mul;     // v <= cur - (i + 1) * digit[i + 1]
    logic fix_add;      // v <= v + r, next digit borrows one
    logic step_commit;  // digit[i] <= v, move to the next digit
    logic write_top;    // digit[top] <= cur
    logic p_select;     // p <= f if it divides, else n
    logic p_from_n;     // p <= n
    logic emit;         // load the output register, n <= n / p
  } pf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic div_done;
    logic div_quo_zero;
    logic top_at_max;
    logic walk_go;    // at least three digits and digit 0 non-zero
    logic v_neg;
    logic i_last;     // current step is the last of the pass
    logic trim_go;    // top digit is zero and can be dropped
    logic out_free;
    logic emit_last;
  } pf_status_t;

endpackage

/* rtl/core/pf_num_if.sv */
// Input channel of the factorisation core: one value per transfer.
// Depends on pf_pkg for the field width.
interface pf_num_if;
  import pf_pkg::*;

  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

/* rtl/core/pf_fac_if.sv */
// Output channel of the factorisation core: one prime factor per transfer.
// Depends on pf_pkg for the field width.
interface pf_fac_if;
  import pf_pkg::*;

  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] prime_factor;
  logic             last_factor;

  modport source (output valid, output prime_factor, output last_factor, input ready);
  modport sink   (input valid, input prime_factor, input last_factor, output ready);
endinterface

/* rtl/core/pf_divider.sv */
// Radix-2 restoring divider, one quotient bit per cycle, shared by the datapath.
// Depends on pf_pkg for the operand width.
module pf_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [pf_pkg::NUM_W-1:0] dividend_i,
  input  logic [pf_pkg::NUM_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [pf_pkg::NUM_W-1:0] quo_o,
  output logic [pf_pkg::NUM_W-1:0] rem_o
);
  import pf_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [NUM_W-1:0]  dvs_q, dvs_d;
  logic [NUM_W:0]    trial;

  // Partial remainder shifted by one bit, minus the divisor; top bit is the borrow
  assign trial = {rem_q, quo_q[NUM_W-1]} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[NUM_W]) begin
        rem_d = {rem_q[NUM_W-2:0], quo_q[NUM_W-1]};
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end else begin
        rem_d = trial[NUM_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Sequencing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  // A result is flagged only once the iteration has stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider flags done while still iterating");

  // The controller never relaunches a division in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

/* rtl/core/pf_datapath.sv */
// Datapath of the factorisation core: working value, digit register file,
// digit renormalisation arithmetic, shared divider and output register.
// Depends on pf_pkg and pf_divider.
module pf_datapath #(
  parameter int unsigned DIGIT_SLOTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pf_pkg::pf_cmd_t          cmd_i,
  output pf_pkg::pf_status_t       sts_o,
  input  logic [pf_pkg::NUM_W-1:0] number_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [pf_pkg::NUM_W-1:0] prime_factor_o,
  output logic                     last_factor_o
);
  import pf_pkg::*;

  localparam int unsigned IDX_W = $clog2(DIGIT_SLOTS);
  localparam int unsigned P_W   = IDX_W + DIG_W;      // (i + 1) * digit
  localparam int unsigned V_W   = DIG_W + IDX_W + 2;  // signed step value
  localparam int unsigned C_W   = DIG_W + 1;          // signed carried digit
  localparam logic [IDX_W-1:0] TOP_MAX = IDX_W'(DIGIT_SLOTS - 1);

  // Working registers
  logic [NUM_W-1:0]        n_q;
  logic [NUM_W-1:0]        x_q;
  logic [NUM_W-1:0]        p_q;
  logic [F_W-1:0]          f_q;
  logic [IDX_W-1:0]        top_q;
  logic [IDX_W-1:0]        i_q;
  logic signed [C_W-1:0]   cur_q;
  logic signed [C_W-1:0]   nxt_q;
  logic signed [V_W-1:0]   v_q;
  logic [R_W-1:0]          r_q;
  logic [RUN_W-1:0]        run_q;
  logic [DIG_W-1:0]        dig_q [DIGIT_SLOTS];

  // Output register
  logic                    out_valid_q;
  logic [NUM_W-1:0]        prime_factor_q;
  logic                    last_factor_q;

  logic [IDX_W-1:0]        idx_nxt;
  logic [IDX_W-1:0]        rd_idx;
  logic [DIG_W-1:0]        rd_dig;
  logic [P_W-1:0]          prod;
  logic signed [V_W-1:0]   v_step;
  logic                    d0_zero;
  logic                    dig_we;
  logic [IDX_W-1:0]        dig_wa;
  logic [DIG_W-1:0]        dig_wd;
  logic                    emit_last;
  logic [NUM_W-1:0]        div_dividend;
  logic [NUM_W-1:0]        div_divisor;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quo;
  logic [NUM_W-1:0]        div_rem;

  // Shared divider: digit conversion and the division by each factor
  assign div_dividend = cmd_i.div_conv ? x_q : n_q;
  assign div_divisor  = cmd_i.div_conv ? (NUM_W'(top_q) + NUM_W'(2)) : p_q;

  pf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Addressed digit read port: next digit during a pass, top digit while trimming; digit 0 is also read directly
  assign idx_nxt = i_q + IDX_W'(1);
  assign rd_idx  = cmd_i.rd_sel_top ? top_q : idx_nxt;
  assign rd_dig  = dig_q[rd_idx];
  assign d0_zero = (dig_q[0] == '0);

  // Step value: cur - (i + 1) * digit[i + 1]
  assign prod   = P_W'(idx_nxt) * P_W'(rd_dig);
  assign v_step = V_W'(cur_q) - $signed(V_W'(prod));

  // Digit write port
  always_comb begin
    dig_we = cmd_i.conv_store | cmd_i.step_commit | cmd_i.write_top;
    dig_wa = cmd_i.step_commit ? i_q : top_q;
    if (cmd_i.conv_store) begin
      dig_wd = div_rem[DIG_W-1:0];
    end else if (cmd_i.step_commit) begin
      dig_wd = v_q[DIG_W-1:0];
    end else begin
      dig_wd = cur_q[DIG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      dig_q[dig_wa] <= dig_wd;
    end
  end

  // Working value, conversion and search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_n) begin
      n_q <= number_i;
    end else if (cmd_i.emit) begin
      n_q <= div_quo;
    end

    if (cmd_i.conv_init) begin
      x_q <= n_q;
    end else if (cmd_i.conv_store) begin
      x_q <= div_quo;
    end

    if (cmd_i.conv_init) begin
      top_q <= '0;
    end else if (cmd_i.top_inc) begin
      top_q <= top_q + IDX_W'(1);
    end else if (cmd_i.top_dec) begin
      top_q <= top_q - IDX_W'(1);
    end

    if (cmd_i.conv_init) begin
      f_q <= F_START;
    end else if (cmd_i.pass_init) begin
      f_q <= f_q + F_W'(1);
    end

    if (cmd_i.pass_init) begin
      i_q <= '0;
    end else if (cmd_i.step_commit) begin
      i_q <= idx_nxt;
    end

    if (cmd_i.pass_init) begin
      cur_q <= $signed(C_W'(dig_q[0]));
    end else if (cmd_i.step_commit) begin
      cur_q <= nxt_q;
    end

    // Borrow from the next digit until the current one is non-negative
    if (cmd_i.step_mul) begin
      v_q   <= v_step;
      nxt_q <= $signed(C_W'(rd_dig));
      r_q   <= R_W'(f_q) + R_W'(i_q);
    end else if (cmd_i.fix_add) begin
      v_q   <= v_q + $signed(V_W'(r_q));
      nxt_q <= nxt_q - C_W'(1);
    end

    if (cmd_i.p_from_n) begin
      p_q <= n_q;
    end else if (cmd_i.p_select) begin
      p_q <= d0_zero ? NUM_W'(f_q) : n_q;
    end

    if (cmd_i.emit) begin
      prime_factor_q <= p_q;
      last_factor_q  <= emit_last;
    end
  end

  // Run length and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_n) begin
        run_q <= '0;
      end else if (cmd_i.emit) begin
        run_q <= run_q + RUN_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status towards the controller
  assign emit_last = (div_quo == NUM_W'(1)) || (run_q == RUN_W'(MAX_RUN - 1));

  always_comb begin
    sts_o.n_zero       = (n_q == '0);
    sts_o.n_one        = (n_q == NUM_W'(1));
    sts_o.div_done     = div_done;
    sts_o.div_quo_zero = (div_quo == '0);
    sts_o.top_at_max   = (top_q == TOP_MAX);
    sts_o.walk_go      = (top_q > IDX_W'(1)) && !d0_zero;
    sts_o.v_neg        = v_q[V_W-1];
    sts_o.i_last       = (idx_nxt == top_q);
    sts_o.trim_go      = (top_q != '0) && (rd_dig == '0);
    sts_o.out_free     = !out_valid_q || out_ready_i;
    sts_o.emit_last    = emit_last;
  end

  assign out_valid_o    = out_valid_q;
  assign prime_factor_o = prime_factor_q;
  assign last_factor_o  = last_factor_q;

  // A factor is never loaded over one still waiting for transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.emit |-> sts_o.out_free)
    else $error("output register overwritten");

  // Only a fully renormalised digit is written back
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.step_commit |-> !v_q[V_W-1])
    else $error("negative digit committed");

  // Conversion digits come from a freshly finished division
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.conv_store |-> div_done)
    else $error("digit stored without a finished division");

endmodule

/* rtl/core/pf_ctrl.sv */
// Controller of the factorisation core: sequences conversion, renormalisation
// passes, division by each factor and output transfers.
// Depends on pf_pkg.
module pf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output pf_pkg::pf_cmd_t    cmd_o,
  input  pf_pkg::pf_status_t sts_i
);
  import pf_pkg::*;

  pf_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.n_zero) begin
          state_d = S_IDLE;
        end else if (sts_i.n_one) begin
          state_d = S_DIV;
        end else begin
          state_d = S_CONV_INIT;
        end
      end
      S_CONV_INIT: state_d = S_CONV;
      S_CONV:      state_d = S_CONV_WAIT;
      S_CONV_WAIT: begin
        if (sts_i.div_done) begin
          if (sts_i.div_quo_zero || sts_i.top_at_max) begin
            state_d = S_CHECK;
          end else begin
            state_d = S_CONV;
          end
        end
      end
      S_CHECK: begin
        state_d = sts_i.walk_go ? S_PASS_INIT : S_RESULT;
      end
      S_PASS_INIT: state_d = S_STEP_MUL;
      S_STEP_MUL:  state_d = S_STEP_FIX;
      S_STEP_FIX: begin
        if (!sts_i.v_neg) begin
          state_d = sts_i.i_last ? S_PASS_END : S_STEP_MUL;
        end
      end
      S_PASS_END: state_d = S_TRIM;
      S_TRIM: begin
        if (!sts_i.trim_go) begin
          state_d = sts_i.walk_go ? S_PASS_INIT : S_RESULT;
        end
      end
      S_RESULT:   state_d = S_DIV;
      S_DIV:      state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.emit_last ? S_IDLE : S_CONV_INIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.load_n = in_valid_i;
      end
      S_LOAD: begin
        cmd_o.p_from_n = sts_i.n_one;
      end
      S_CONV_INIT: cmd_o.conv_init = 1'b1;
      S_CONV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_conv  = 1'b1;
      end
      S_CONV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.conv_store = 1'b1;
          cmd_o.top_inc    = !(sts_i.div_quo_zero || sts_i.top_at_max);
        end
      end
      S_CHECK:     cmd_o = '0;
      S_PASS_INIT: cmd_o.pass_init = 1'b1;
      S_STEP_MUL:  cmd_o.step_mul = 1'b1;
      S_STEP_FIX: begin
        cmd_o.fix_add     = sts_i.v_neg;
        cmd_o.step_commit = !sts_i.v_neg;
      end
      S_PASS_END: cmd_o.write_top = 1'b1;
      S_TRIM: begin
        cmd_o.rd_sel_top = 1'b1;
        cmd_o.top_dec    = sts_i.trim_go;
      end
      S_RESULT:   cmd_o.p_select = 1'b1;
      S_DIV:      cmd_o.div_start = 1'b1;
      S_DIV_WAIT: cmd_o = '0;
      S_EMIT:     cmd_o.emit = sts_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The final factor of a run always frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_o.emit && sts_i.emit_last |=> state_q == S_IDLE)
    else $error("run did not end after its last factor");

endmodule

/* rtl/core/prime_factorization_top.sv */
// Prime factorisation core: one value in, its prime factors out, smallest first.
// Per factor, the value is converted to mixed-radix digits (12 digits at most), then the
// digit renormalisation loop runs once per trial divisor; a prime near 2^31 needs roughly
// 46 000 trial divisors. One value at a time.
// Reset: asynchronous, active low; clears the controller and output valid, no value in flight.
// Depends on pf_pkg, pf_num_if, pf_fac_if, pf_ctrl, pf_datapath.
module prime_factorization_top #(
  parameter int unsigned DIGIT_SLOTS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pf_num_if.sink   num_chan_i,
  pf_fac_if.source fac_chan_o
);
  import pf_pkg::*;

  pf_cmd_t    cmd;
  pf_status_t sts;

  // Sequencer
  pf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (num_chan_i.valid),
    .in_ready_o (num_chan_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Arithmetic, digit storage and output register
  pf_datapath #(
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .number_i       (num_chan_i.number),
    .out_ready_i    (fac_chan_o.ready),
    .out_valid_o    (fac_chan_o.valid),
    .prime_factor_o (fac_chan_o.prime_factor),
    .last_factor_o  (fac_chan_o.last_factor)
  );

endmodule

/* test/prime_factorization_top_test.sv */
// Self-checking testbench for prime_factorization_top: drives values to factor and checks
// every factor and run-end marker against a behavioural mixed-radix trial-division model.
// Depends on pf_pkg, pf_num_if, pf_fac_if and the factorisation core RTL.
module prime_factorization_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pf_pkg::*;

  localparam int          DIGIT_SLOTS  = 16;
  localparam int unsigned NUM_MAX      = 32'h7FFF_FFFF;
  localparam int          RANDOM_ITEMS = 80;
  localparam int          HOLD_CYCLES  = 4000;      // long receiver hold-off, applied once
  localparam int          HOLD_AT_ITEM = 40;        // values taken before the hold-off starts
  localparam int          DRAIN_CYCLES = 2000;
  localparam longint      CYCLE_LIMIT  = 250_000_000;

  typedef struct {
    logic [NUM_W-1:0] prime_factor;
    logic             last_factor;
  } factor_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pf_num_if num_chan ();
  pf_fac_if fac_chan ();

  prime_factorization_top #(
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .num_chan_i (num_chan),
    .fac_chan_o (fac_chan)
  );

  logic [NUM_W-1:0] pending_numbers[$];
  factor_t          expected_factors[$];

  logic   num_taken;
  int     send_gap;
  int     stall_left;
  int     hold_left;
  logic   hold_done;
  int     values_taken  = 0;
  int     zeros_taken   = 0;
  int     factors_seen  = 0;
  int     errors        = 0;
  longint cycle_count   = 0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Smallest prime factor of value, found by renormalising its mixed-radix digits
  function automatic logic [NUM_W-1:0] least_divisor(input logic [NUM_W-1:0] value);
    longint digit[DIGIT_SLOTS];
    longint rest;
    longint radix;
    longint trial;
    longint v;
    longint r;
    longint borrow;
    int     top;
    top   = -1;
    rest  = longint'(value);
    radix = 2;
    while (rest != 0 && top < DIGIT_SLOTS - 1) begin
      top++;
      digit[top] = rest % radix;
      rest       = rest / radix;
      radix++;
    end
    if (top < 0) return value;
    trial = 2;
    while (top > 1 && digit[0] != 0) begin
      trial++;
      for (int i = 0; i < top; i++) begin
        r = trial + i;
        v = digit[i] - longint'(i + 1) * digit[i+1];
        if (v < 0) begin
          borrow     = (-v + r - 1) / r;
          v          = v + borrow * r;
          digit[i+1] = digit[i+1] - borrow;
        end
        digit[i] = v;
      end
      while (top > 0 && digit[top] == 0) top--;
    end
    if (digit[0] == 0) return NUM_W'(trial);
    return value;
  endfunction

  // Queue the run of factors that one accepted value should produce
  function automatic void queue_factors(input logic [NUM_W-1:0] value);
    logic [NUM_W-1:0] rest;
    logic [NUM_W-1:0] p;
    factor_t          f;
    int               count;
    rest  = value;
    count = 0;
    if (rest == 0) return;  // zero is dropped by the core
    if (rest == 1) begin
      f.prime_factor = NUM_W'(1);
      f.last_factor  = 1'b1;
      expected_factors.push_back(f);
      return;
    end
    while (rest != 1 && count < MAX_RUN) begin
      p = least_divisor(rest);
      if (p < 2) p = rest;
      rest           = rest / p;
      f.prime_factor = p;
      f.last_factor  = (rest == 1) || (count == MAX_RUN - 1);
      expected_factors.push_back(f);
      count++;
    end
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(40, 150);
  endfunction

  // Random value; mostly products of small factors so the searches stay short
  function automatic logic [NUM_W-1:0] random_value();
    int unsigned pick;
    int          steps;
    longint      acc;
    longint      m;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      acc   = 1;
      steps = $urandom_range(1, 12);
      for (int s = 0; s < steps; s++) begin
        m = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 400) : $urandom_range(2, 40);
        if (acc * m <= longint'(NUM_MAX)) acc = acc * m;
      end
      return NUM_W'(acc);
    end
    if (pick < 85) return NUM_W'($urandom_range(1, 4095));
    if (pick < 98) return NUM_W'($urandom_range(1, 1 << 20));
    return NUM_W'($urandom_range(1, NUM_MAX));
  endfunction

  // Input driver: offers the next pending value once the previous transfer is done
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_chan.valid  <= 1'b0;
      num_chan.number <= '0;
      send_gap        <= 0;
    end else if (!num_chan.valid || num_taken) begin
      if (send_gap > 0) begin
        num_chan.valid <= 1'b0;
        send_gap       <= send_gap - 1;
      end else if (pending_numbers.size() > 0) begin
        num_chan.valid  <= 1'b1;
        num_chan.number <= pending_numbers.pop_front();
        send_gap        <= pick_gap();
      end else begin
        num_chan.valid <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls plus one long hold-off to back up the core
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fac_chan.ready <= 1'b0;
      stall_left     <= 0;
      hold_left      <= 0;
      hold_done      <= 1'b0;
    end else if (hold_left > 0) begin
      fac_chan.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (!hold_done && values_taken >= HOLD_AT_ITEM) begin
      fac_chan.ready <= 1'b0;
      hold_left      <= HOLD_CYCLES;
      hold_done      <= 1'b1;
    end else if (stall_left > 0) begin
      fac_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else begin
      fac_chan.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Monitor: check factor transfers, then predict for each accepted value
  always @(posedge clk_i or negedge rst_ni) begin
    factor_t want;
    if (!rst_ni) begin
      num_taken <= 1'b0;
    end else begin
      if (fac_chan.valid && fac_chan.ready) begin
        factors_seen++;
        if (expected_factors.size() == 0) begin
          $error("unexpected factor %0d (last %0b)", fac_chan.prime_factor,
                 fac_chan.last_factor);
          errors++;
        end else begin
          want = expected_factors.pop_front();
          if (fac_chan.prime_factor !== want.prime_factor) begin
            $error("prime_factor: expected %0d, got %0d", want.prime_factor,
                   fac_chan.prime_factor);
            errors++;
          end
          if (fac_chan.last_factor !== want.last_factor) begin
            $error("last_factor: expected %0b, got %0b", want.last_factor,
                   fac_chan.last_factor);
            errors++;
          end
        end
      end
      num_taken <= num_chan.valid && num_chan.ready;
      if (num_chan.valid && num_chan.ready) begin
        queue_factors(num_chan.number);
        values_taken++;
        if (num_chan.number == 0) zeros_taken++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int random_count;
    rst_ni = 1'b0;
    // Corner values: one, zero (ignored), small primes and powers, a prime square,
    // thirty factors of two, thirty factors with a three on top, alternating bit
    // patterns, and the two largest values
    pending_numbers = '{31'd1, 31'd0, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd7, 31'd8,
                        31'd9, 31'd25, 31'd30030, 31'd999983, 31'd16752649,
                        31'd1073741824, 31'd1610612736, 31'd715827882, 31'd1431655765,
                        31'd2147483646, 31'd2147483647};
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 29) == 0) begin
        pending_numbers.push_back('0);
      end else begin
        pending_numbers.push_back(random_value());
        random_count++;
      end
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_numbers.size() != 0 || num_chan.valid || expected_factors.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d values factored (%0d zero), %0d factors compared in %0d cycles",
             values_taken, zeros_taken, factors_seen, cycle_count);
    $display("tb: output held off once for %0d cycles while input kept offering",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
